// ===== sv/slc_pkg.sv =====
package slc_pkg;

	// list size and derived widths
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 16;
	localparam int ID_W     = 16;
	localparam int ENTRY_W  = KEY_W + ID_W;
	localparam int POS_W    = 7;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// configuration port
	localparam int PADDR_W  = 2;
	localparam int PDATA_W  = 32;
	localparam logic [PADDR_W-1:0] ADDR_REPEAT = 2'd0;

	// request commands
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_NEXT   = 2'd2,
		OP_PREV   = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_BAD_POS = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic decode;
		logic ins_read;
		logic ins_shift;
		logic ins_place;
		logic ins_done;
		logic rem_read;
		logic rem_shift;
		logic rem_done;
		logic out_load;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic ins_ok;
		logic rem_ok;
		logic idx_zero;
		logic key_gt;
		logic rem_more;
		logic out_free;
	} dp_status_t;

endpackage

// ===== sv/sorted_list_with_cursor_top.sv =====
// Sorted list of up to CAPACITY (key, id) entries in ascending key order with a cursor.
// One request is handled at a time: insert, remove by 1-based position, next or previous,
// each answered by one result with status, entry count and the entry under the cursor.
// An insert walks down from the tail one entry at a time: each entry is read
// from the entry memory (registered read) and its key compared before it moves up one
// slot, until it meets a key no larger than its own or reaches the head; a remove closes
// the gap by moving each entry behind it down one slot. The result is held in an output
// register, so a new request is taken while the last result waits.
// repeat_enable sits at address 0 of the APB port; write it only while the block is idle.
module sorted_list_with_cursor_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [1:0]                   cmd,
	input  logic [slc_pkg::KEY_W-1:0]    entry_key,
	input  logic [slc_pkg::ID_W-1:0]     entry_id,
	input  logic [slc_pkg::POS_W-1:0]    remove_position,
	// result channel
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [1:0]                   status,
	output logic [slc_pkg::POS_W-1:0]    entry_count,
	output logic                         cursor_valid,
	output logic [slc_pkg::POS_W-1:0]    cursor_position,
	output logic [slc_pkg::KEY_W-1:0]    cursor_key,
	output logic [slc_pkg::ID_W-1:0]     cursor_id,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [slc_pkg::PADDR_W-1:0]  paddr,
	input  logic [slc_pkg::PDATA_W-1:0]  pwdata,
	output logic [slc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import slc_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t dst;
	logic       repeat_q;
	logic       reg_sel;

	// configuration register
	assign reg_sel = (paddr == ADDR_REPEAT);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? PDATA_W'(repeat_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_sel) begin
			repeat_q <= pwdata[0];
		end
	end

	slc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (dst),
		.cmd       (ctl)
	);

	slc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctl),
		.st            (dst),
		.repeat_enable (repeat_q),
		.req_cmd       (cmd),
		.req_key       (entry_key),
		.req_id        (entry_id),
		.req_rpos      (remove_position),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res_status    (status),
		.res_count     (entry_count),
		.res_cur_valid (cursor_valid),
		.res_cur_pos   (cursor_position),
		.res_cur_key   (cursor_key),
		.res_cur_id    (cursor_id)
	);

endmodule

// ===== sv/slc_ram.sv =====
module slc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/slc_ctrl.sv =====
module slc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  slc_pkg::dp_status_t st,
	output slc_pkg::ctrl_cmd_t  cmd
);
	import slc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_INS_RD = 8'b0000_0100,
		S_INS_WR = 8'b0000_1000,
		S_REM_RD = 8'b0001_0000,
		S_REM_WR = 8'b0010_0000,
		S_CUR_RD = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (st.op == OP_INSERT && st.ins_ok) begin
					state_d = S_INS_RD;
				end else if (st.op == OP_REMOVE && st.rem_ok) begin
					state_d = S_REM_RD;
				end else begin
					state_d = S_CUR_RD;
				end
			end
			// walk down from the tail, shifting larger keys up one slot
			S_INS_RD: begin
				if (st.idx_zero) begin
					cmd.ins_place = 1'b1;
					cmd.ins_done  = 1'b1;
					state_d       = S_CUR_RD;
				end else begin
					cmd.ins_read = 1'b1;
					state_d      = S_INS_WR;
				end
			end
			S_INS_WR: begin
				if (st.key_gt) begin
					cmd.ins_shift = 1'b1;
					state_d       = S_INS_RD;
				end else begin
					cmd.ins_place = 1'b1;
					cmd.ins_done  = 1'b1;
					state_d       = S_CUR_RD;
				end
			end
			// close the gap left by the removed entry
			S_REM_RD: begin
				if (st.rem_more) begin
					cmd.rem_read = 1'b1;
					state_d      = S_REM_WR;
				end else begin
					cmd.rem_done = 1'b1;
					state_d      = S_CUR_RD;
				end
			end
			S_REM_WR: begin
				cmd.rem_shift = 1'b1;
				state_d       = S_REM_RD;
			end
			S_CUR_RD: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/slc_dp.sv =====
module slc_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  slc_pkg::ctrl_cmd_t          cmd,
	output slc_pkg::dp_status_t         st,
	input  logic                        repeat_enable,
	input  logic [1:0]                  req_cmd,
	input  logic [slc_pkg::KEY_W-1:0]   req_key,
	input  logic [slc_pkg::ID_W-1:0]    req_id,
	input  logic [slc_pkg::POS_W-1:0]   req_rpos,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [1:0]                  res_status,
	output logic [slc_pkg::POS_W-1:0]   res_count,
	output logic                        res_cur_valid,
	output logic [slc_pkg::POS_W-1:0]   res_cur_pos,
	output logic [slc_pkg::KEY_W-1:0]   res_cur_key,
	output logic [slc_pkg::ID_W-1:0]    res_cur_id
);
	import slc_pkg::*;

	// request fields
	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [ID_W-1:0]   id_q;
	logic [POS_W-1:0]  rpos_q;

	// list state
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  cursor_q;
	logic [IDX_W-1:0]  idx_q;
	status_t           status_q;
	logic              res_valid_q;

	// memory port
	logic               wr_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [ENTRY_W-1:0] rd_data;

	// helpers
	logic [IDX_W-1:0]  rm_idx;
	logic [CNT_W-1:0]  rm_idx_ext;
	logic [CNT_W-1:0]  cur_ext;
	logic [CNT_W-1:0]  idx_ext;
	logic [CNT_W-1:0]  cur_pos;
	logic              list_empty;

	assign rm_idx     = IDX_W'(rpos_q - POS_W'(1));
	assign rm_idx_ext = CNT_W'(rm_idx);
	assign cur_ext    = CNT_W'(cursor_q);
	assign idx_ext    = CNT_W'(idx_q);
	assign cur_pos    = cur_ext + CNT_W'(1);
	assign list_empty = (count_q == '0);

	// status toward the controller
	always_comb begin
		st.op       = op_q;
		st.ins_ok   = (count_q < CNT_W'(CAPACITY));
		st.rem_ok   = (rpos_q != '0) && (CMP_W'(rpos_q) <= CMP_W'(count_q));
		st.idx_zero = (idx_q == '0);
		st.key_gt   = (rd_data[ENTRY_W-1:ID_W] > key_q);
		st.rem_more = ((idx_ext + CNT_W'(1)) < count_q);
		st.out_free = !res_valid_q || res_ready;
	end

	// memory address and data
	always_comb begin
		wr_en   = cmd.ins_place || cmd.ins_shift || cmd.rem_shift;
		wr_data = cmd.ins_place ? {key_q, id_q} : rd_data;
		if (cmd.ins_read) begin
			rd_addr = idx_q - IDX_W'(1);
		end else if (cmd.rem_read) begin
			rd_addr = idx_q + IDX_W'(1);
		end else begin
			rd_addr = cursor_q;
		end
	end

	slc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_q),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// request latch and walk index
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(req_cmd);
			key_q  <= req_key;
			id_q   <= req_id;
			rpos_q <= req_rpos;
		end
		if (cmd.decode) begin
			if (op_q == OP_INSERT) begin
				idx_q <= IDX_W'(count_q);
			end else begin
				idx_q <= rm_idx;
			end
		end else if (cmd.ins_shift) begin
			idx_q <= idx_q - IDX_W'(1);
		end else if (cmd.rem_shift) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// count, cursor and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			status_q <= ST_OK;
		end else begin
			if (cmd.decode) begin
				status_q <= ST_OK;
				case (op_q)
					OP_INSERT: begin
						if (!st.ins_ok) begin
							status_q <= ST_FULL;
						end
					end
					OP_REMOVE: begin
						if (!st.rem_ok) begin
							status_q <= ST_BAD_POS;
						end else if (rm_idx == cursor_q) begin
							if ((rm_idx_ext + CNT_W'(1)) < count_q) begin
								cursor_q <= rm_idx;
							end else if (count_q == CNT_W'(1)) begin
								cursor_q <= '0;
							end else begin
								cursor_q <= rm_idx - IDX_W'(1);
							end
						end else if (rm_idx < cursor_q) begin
							cursor_q <= cursor_q - IDX_W'(1);
						end
					end
					OP_NEXT: begin
						if (!list_empty) begin
							if (cur_pos >= count_q) begin
								if (repeat_enable) begin
									cursor_q <= '0;
								end
							end else begin
								cursor_q <= cursor_q + IDX_W'(1);
							end
						end
					end
					default: begin
						if (!list_empty && cursor_q != '0) begin
							cursor_q <= cursor_q - IDX_W'(1);
						end
					end
				endcase
			end
			// insert lands at idx_q
			if (cmd.ins_done) begin
				count_q <= count_q + CNT_W'(1);
				if (list_empty) begin
					cursor_q <= '0;
				end else if (cursor_q >= idx_q) begin
					cursor_q <= cursor_q + IDX_W'(1);
				end
			end
			if (cmd.rem_done) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_status    <= status_q;
			res_count     <= POS_W'(count_q);
			res_cur_valid <= !list_empty;
			res_cur_pos   <= list_empty ? '0 : POS_W'(cur_pos);
			res_cur_key   <= list_empty ? '0 : rd_data[ENTRY_W-1:ID_W];
			res_cur_id    <= list_empty ? '0 : rd_data[ID_W-1:0];
		end
	end

	assign res_valid = res_valid_q;

endmodule
